// ===== rtl/core/fec_pkg.sv =====
// ----------------------------------------------------------------------------
// fec_pkg
// Types, constants and character tables shared by the file name escape codec.
// ----------------------------------------------------------------------------
package fec_pkg;

  localparam int unsigned Q_DEPTH = 4;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_ESCAPE = 2'd1;
  localparam logic [1:0] ST_BAD_CTRL   = 2'd2;
  localparam logic [1:0] ST_INCOMPLETE = 2'd3;

  localparam logic [7:0] CH_ESC   = 8'h5F;  // '_'
  localparam logic [7:0] CH_FLIP  = 8'h2D;  // '-'
  localparam logic [7:0] CH_CTRL  = 8'h6E;  // 'n'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CH_LOW_V = 8'h76;  // 'v'
  localparam logic [7:0] CTRL_BASE = 8'd32;
  localparam logic [7:0] DEC_DIGITS = 8'd10;
  localparam logic [7:0] LETTER_OFS = 8'd87;  // 'a' - 10
  localparam logic [7:0] CASE_OFS   = 8'd32;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       name_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last_of_run;
    logic       name_done;
    logic [1:0] status;
  } out_item_t;

  // One input item worth of results: one to three bytes, or a bare end marker.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      cnt;
    logic            has_byte;
    logic            name_end;
    logic [1:0]      status;
  } job_t;

  function automatic logic is_up(input logic [7:0] b);
    return (b >= 8'h41) && (b <= 8'h5A);
  endfunction

  function automatic logic is_low(input logic [7:0] b);
    return (b >= 8'h61) && (b <= 8'h7A);
  endfunction

  function automatic logic [7:0] to_low(input logic [7:0] b);
    return is_up(b) ? b + CASE_OFS : b;
  endfunction

  function automatic logic [7:0] to_up(input logic [7:0] b);
    return is_low(b) ? b - CASE_OFS : b;
  endfunction

  // Escape letter of a reserved byte, zero when not reserved.
  function automatic logic [7:0] esc_letter(input logic [7:0] b);
    logic [7:0] r;
    case (b)
      8'h2F:   r = 8'h73;  // '/'  s
      8'h5C:   r = 8'h62;  // '\'  b
      8'h3A:   r = 8'h63;  // ':'  c
      8'h2A:   r = 8'h61;  // '*'  a
      8'h3F:   r = 8'h71;  // '?'  q
      8'h22:   r = 8'h64;  // '"'  d
      8'h3C:   r = 8'h6C;  // '<'  l
      8'h3E:   r = 8'h67;  // '>'  g
      8'h7C:   r = 8'h70;  // '|'  p
      8'h2E:   r = 8'h78;  // '.'  x
      8'h20:   r = 8'h5F;  // ' '  _
      8'h5F:   r = 8'h75;  // '_'  u
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // Reserved byte of a lower case escape letter; bit 8 flags a valid letter.
  function automatic logic [8:0] unescape(input logic [7:0] l);
    logic [8:0] r;
    case (l)
      8'h73:   r = {1'b1, 8'h2F};
      8'h62:   r = {1'b1, 8'h5C};
      8'h63:   r = {1'b1, 8'h3A};
      8'h61:   r = {1'b1, 8'h2A};
      8'h71:   r = {1'b1, 8'h3F};
      8'h64:   r = {1'b1, 8'h22};
      8'h6C:   r = {1'b1, 8'h3C};
      8'h67:   r = {1'b1, 8'h3E};
      8'h70:   r = {1'b1, 8'h7C};
      8'h78:   r = {1'b1, 8'h2E};
      8'h5F:   r = {1'b1, 8'h20};
      8'h75:   r = {1'b1, 8'h5F};
      default: r = 9'h000;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/fec_front.sv =====
// ----------------------------------------------------------------------------
// fec_front
// Accepts input items, holds the mode and per-name state, and turns each item
// into a job of one to three result bytes, an end-of-name marker, or nothing.
// ----------------------------------------------------------------------------
module fec_front
  import fec_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     cfg_we,
  input  logic     cfg_data,
  input  logic     push,
  output logic     full,
  input  in_item_t in_item,
  input  logic     q_full,
  output logic     q_push,
  output job_t     q_job
);

  logic       codec_mode;
  logic       upper_case_mode, upper_case_mode_next;
  logic       escape_pending, escape_pending_next;
  logic       control_pending, control_pending_next;
  logic       name_failed, name_failed_next;
  logic [1:0] fail_code, fail_code_next;
  logic       accept;
  logic       need_job;
  job_t       job;

  always_comb begin
    logic [7:0] b;
    logic [7:0] e;
    logic [7:0] l;
    logic [8:0] u;
    logic [1:0] n;
    b = in_item.in_byte;
    e = esc_letter(b);
    l = to_low(b);
    u = unescape(l);
    n = 2'd0;
    job = '0;
    upper_case_mode_next = upper_case_mode;
    escape_pending_next  = escape_pending;
    control_pending_next = control_pending;
    name_failed_next     = name_failed;
    fail_code_next       = fail_code;
    if (codec_mode == MODE_ENCODE) begin
      if (e != 8'h00) begin
        job.bytes[0] = CH_ESC;
        job.bytes[1] = e;
        n = 2'd2;
      end else if (b < CTRL_BASE) begin
        job.bytes[0] = CH_ESC;
        job.bytes[1] = CH_CTRL;
        job.bytes[2] = (b < DEC_DIGITS) ? b + CH_ZERO : b + LETTER_OFS;
        n = 2'd3;
      end else if ((is_up(b) || is_low(b)) && (is_up(b) != upper_case_mode)) begin
        job.bytes[0] = CH_ESC;
        job.bytes[1] = CH_FLIP;
        job.bytes[2] = b;
        n = 2'd3;
        upper_case_mode_next = ~upper_case_mode;
      end else begin
        job.bytes[0] = b;
        n = 2'd1;
      end
    end else begin
      if (!name_failed) begin
        if (escape_pending) begin
          if (u[8]) begin
            job.bytes[0] = u[7:0];
            n = 2'd1;
          end else if (l == CH_FLIP) begin
            upper_case_mode_next = ~upper_case_mode;
          end else if (l == CH_CTRL) begin
            control_pending_next = 1'b1;
          end else begin
            name_failed_next = 1'b1;
            fail_code_next   = ST_BAD_ESCAPE;
          end
          escape_pending_next = 1'b0;
        end else if (b == CH_ESC) begin
          escape_pending_next = 1'b1;
        end else if (control_pending) begin
          if ((b >= CH_ZERO) && (b <= CH_NINE)) begin
            job.bytes[0] = b - CH_ZERO;
            n = 2'd1;
          end else if ((is_up(b) || is_low(b)) && (l <= CH_LOW_V)) begin
            job.bytes[0] = l - LETTER_OFS;
            n = 2'd1;
          end else begin
            name_failed_next = 1'b1;
            fail_code_next   = ST_BAD_CTRL;
          end
          control_pending_next = 1'b0;
        end else begin
          job.bytes[0] = upper_case_mode ? to_up(b) : l;
          n = 2'd1;
        end
      end
      if (in_item.name_end) begin
        if (!name_failed_next && (escape_pending_next || control_pending_next)) begin
          name_failed_next = 1'b1;
          fail_code_next   = ST_INCOMPLETE;
        end
        if (name_failed_next) begin
          n = 2'd0;
          job.status = fail_code_next;
        end
      end
    end
    job.has_byte = (n != 2'd0);
    job.cnt      = (n == 2'd0) ? 2'd1 : n;
    job.name_end = in_item.name_end;
    need_job     = (n != 2'd0) || in_item.name_end;
  end

  assign full   = q_full;
  assign accept = push && !q_full;
  assign q_push = accept && need_job;
  assign q_job  = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      codec_mode      <= MODE_ENCODE;
      upper_case_mode <= 1'b1;
      escape_pending  <= 1'b0;
      control_pending <= 1'b0;
      name_failed     <= 1'b0;
      fail_code       <= ST_OK;
    end else begin
      if (cfg_we) begin
        codec_mode <= cfg_data;
      end
      if (accept) begin
        if (in_item.name_end) begin
          upper_case_mode <= 1'b1;
          escape_pending  <= 1'b0;
          control_pending <= 1'b0;
          name_failed     <= 1'b0;
          fail_code       <= ST_OK;
        end else begin
          upper_case_mode <= upper_case_mode_next;
          escape_pending  <= escape_pending_next;
          control_pending <= control_pending_next;
          name_failed     <= name_failed_next;
          fail_code       <= fail_code_next;
        end
      end
    end
  end

endmodule

// ===== rtl/core/fec_queue.sv =====
// ----------------------------------------------------------------------------
// fec_queue
// Small job queue between the front and the back.
// ----------------------------------------------------------------------------
module fec_queue
  import fec_pkg::*;
#(
  parameter int unsigned QDEPTH = Q_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic q_push,
  input  job_t q_wdata,
  output logic q_full,
  input  logic q_pop,
  output logic q_valid,
  output job_t q_rdata
);

  localparam int unsigned PW = $clog2(QDEPTH);
  localparam int unsigned CW = $clog2(QDEPTH + 1);

  job_t          mem [QDEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign q_full  = (count == CW'(QDEPTH));
  assign q_valid = (count != '0);
  assign q_rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (q_push) begin
      mem[wr_ptr] <= q_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (q_push) begin
        wr_ptr <= (wr_ptr == PW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (q_push && !q_pop) begin
        count <= count + 1'b1;
      end else if (!q_push && q_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) q_full |-> !q_push)
    else $error("job queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !q_valid |-> !q_pop)
    else $error("job queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CW'(QDEPTH))
    else $error("job queue count out of range");

endmodule

// ===== rtl/core/fec_back.sv =====
// ----------------------------------------------------------------------------
// fec_back
// Takes queue jobs; hands out result items one per cycle while pop is high.
// ----------------------------------------------------------------------------
module fec_back
  import fec_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  input  job_t      q_rdata,
  output logic      q_pop,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  job_t       cur;
  logic       busy;
  logic [1:0] idx;
  logic       last;
  logic       take;

  assign last  = (idx == cur.cnt - 2'd1);
  assign take  = busy && pop;
  assign q_pop = q_valid && (!busy || (take && last));
  assign empty = !busy;

  always_comb begin
    out_item             = '0;
    out_item.byte_valid  = cur.has_byte;
    out_item.out_byte    = cur.has_byte ? cur.bytes[idx] : 8'h00;
    out_item.last_of_run = last;
    out_item.name_done   = last && cur.name_end;
    out_item.status      = cur.status;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (q_pop) begin
      busy <= 1'b1;
      idx  <= 2'd0;
    end else if (take) begin
      if (last) begin
        busy <= 1'b0;
        idx  <= 2'd0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  a_idx_in_job: assert property (@(posedge clk) disable iff (rst) busy |-> idx < cur.cnt)
    else $error("result index past end of job");
  a_status_bare: assert property (@(posedge clk) disable iff (rst)
    (busy && cur.status != ST_OK) |-> (!cur.has_byte && cur.name_end))
    else $error("error status on an item carrying a byte");

endmodule

// ===== rtl/core/filename_escape_codec_core.sv =====
// ----------------------------------------------------------------------------
// filename_escape_codec_core
// Byte-stream codec that escapes file names into a portable form and back.
// ----------------------------------------------------------------------------
// Each input item is classified in the cycle it is accepted and produces zero
// to three result items (zero for a decode byte that yields nothing), handed
// out at one per cycle from the back end while pop is asserted; a four-entry
// job queue decouples input from output, so input is taken every cycle until
// the queue fills. Sustained rate is set by the output port, one result item
// per pop; escapes that carry a control digit or a case flip give three.
// cfg_we/cfg_data set the mode (0 encode, 1 decode) and must only be written
// while the block is idle.
module filename_escape_codec_core
  import fec_pkg::*;
#(
  parameter int unsigned QDEPTH = Q_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic      cfg_data,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_valid;
  job_t q_wdata;
  job_t q_rdata;

  fec_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (q_wdata)
  );

  fec_queue #(
    .QDEPTH (QDEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .q_push  (q_push),
    .q_wdata (q_wdata),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_valid (q_valid),
    .q_rdata (q_rdata)
  );

  fec_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_rdata  (q_rdata),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule
